/* sv/rieu_pkg.sv */
// Shared types and constants of the integer execute unit.
// Holds opcode, funct, operation, fault and configuration register codes plus the controller/datapath structs.
// No dependencies.
package rieu_pkg;

  // Default data memory size in bytes; must be a power of two from 64 upwards.
  localparam int unsigned MEM_BYTES_DEF = 4096;

  // Item operations.
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_OVF   = 2'd1;
  localparam logic [1:0] FAULT_MISAL = 2'd2;
  localparam logic [1:0] FAULT_RANGE = 2'd3;

  // Configuration register indexes.
  localparam logic REG_TEXT_START = 1'b0;
  localparam logic REG_MEM_LIMIT  = 1'b1;

  // Primary opcodes.
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTI    = 6'h0a;
  localparam logic [5:0] OPC_SLTIU   = 6'h0b;
  localparam logic [5:0] OPC_ANDI    = 6'h0c;
  localparam logic [5:0] OPC_ORI     = 6'h0d;
  localparam logic [5:0] OPC_XORI    = 6'h0e;
  localparam logic [5:0] OPC_LB      = 6'h20;
  localparam logic [5:0] OPC_LH      = 6'h21;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_LBU     = 6'h24;
  localparam logic [5:0] OPC_LHU     = 6'h25;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_SH      = 6'h29;
  localparam logic [5:0] OPC_SW      = 6'h2b;

  // Funct codes of the special opcode.
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  typedef struct packed {
    logic capture;   // latch the incoming beat
    logic exec;      // decode, execute and commit
    logic finish;    // complete a memory read
    logic res_we;    // keep the current result
    logic out_load;  // load the output register
    logic out_sel;   // take the kept result rather than the live one
  } rieu_cmd_t;

  typedef struct packed {
    logic needs_load;
  } rieu_status_t;

endpackage

/* sv/rieu_ram.sv */
// Generic simple dual-port RAM with a registered read.
// One write and one read address per cycle. No dependencies.
module rieu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rieu_ctrl.sv */
// Controller of the integer execute unit: sequences capture, execute, load and output.
// Depends on rieu_pkg.
module rieu_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  rieu_pkg::rieu_status_t status_i,
  output rieu_pkg::rieu_cmd_t    cmd_o
);
  import rieu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec   = 1'b1;
        cmd_o.res_we = 1'b1;
        if (status_i.needs_load) begin
          state_d = S_LOAD;
        end else if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_LOAD: begin
        cmd_o.finish = 1'b1;
        cmd_o.res_we = 1'b1;
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A held result only exists while the previous one is still unclaimed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOLD |-> out_valid_q)
    else $error("hold state without a pending output");

  // The output register is never overwritten while its beat is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("pending output overwritten");

  // A memory read completes only straight after an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> $past(state_q) == S_EXEC)
    else $error("load state entered out of sequence");
`endif

endmodule

/* sv/rieu_dp.sv */
// Datapath of the integer execute unit: register file, byte memory lanes, ALU, PC, output.
// Depends on rieu_pkg and rieu_ram.
module rieu_dp #(
  parameter int unsigned MemBytes = rieu_pkg::MEM_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rieu_pkg::rieu_cmd_t    cmd_i,
  output rieu_pkg::rieu_status_t status_o,
  input  logic [11:0]           text_start_i,
  input  logic [12:0]           memory_limit_i,
  input  logic [1:0]            operation_i,
  input  logic [31:0]           instruction_i,
  input  logic [11:0]           byte_address_i,
  input  logic [7:0]            byte_value_i,
  output logic [31:0]           next_pc_o,
  output logic [1:0]            fault_o,
  output logic [7:0]            read_byte_o
);
  import rieu_pkg::*;

  localparam int unsigned AddrW = $clog2(MemBytes);
  localparam int unsigned WordW = AddrW - 2;
  localparam int unsigned Words = MemBytes / 4;
  localparam logic [33:0] MemBytes34 = 34'(MemBytes);

  // Captured beat.
  logic [1:0]  op_q;
  logic [31:0] ins_q;
  logic [11:0] ba_q;
  logic [7:0]  bv_q;

  // Architectural and carried state.
  logic [31:0] pc_q, pc_d;
  logic [1:0]  fault_q, fault_d;
  logic [1:0]  off_q;
  logic        ld_ok_q, ld_ok_d;
  logic [31:0] rf_vld_q;
  logic        a_vld_q, b_vld_q;

  // Kept and output results.
  logic [31:0] res_pc_q, out_pc_q, live_pc;
  logic [1:0]  res_fault_q, out_fault_q, live_fault;
  logic [7:0]  res_rb_q, out_rb_q, live_rb;

  // Register file ports.
  logic [31:0] a_raw, b_raw, a, b;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        ex_we;
  logic [4:0]  ex_wa;
  logic [31:0] ex_wd;

  // Decode fields.
  logic [5:0]  opc, fn;
  logic [4:0]  rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, pc4, jtarget;

  // ALU terms.
  logic [32:0] sum_rr, sum_ri;
  logic [31:0] prod;

  // Memory access terms.
  logic signed [33:0] idx, idx_end, low, lim;
  logic [2:0]  size;
  logic        is_mem, is_store, is_load, acc_ok, misal;
  logic        ba_ok;
  logic [20:0] ba_ext;
  logic [1:0]  off;
  logic [WordW-1:0] wbase;
  logic        mem_wr;

  // Lane ports.
  logic             lane_we   [4];
  logic [WordW-1:0] lane_addr [4];
  logic [7:0]       lane_wd   [4];
  logic [7:0]       lane_rd   [4];

  // Load path.
  logic [31:0] ld_word, ld_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      ins_q <= instruction_i;
      ba_q  <= byte_address_i;
      bv_q  <= byte_value_i;
    end
  end

  // Register file: two copies for the two read ports, written together.
  rieu_ram #(.Width(32), .Depth(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_wa),
    .wdata_i (rf_wd),
    .raddr_i (instruction_i[25:21]),
    .rdata_o (a_raw)
  );

  rieu_ram #(.Width(32), .Depth(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_wa),
    .wdata_i (rf_wd),
    .raddr_i (instruction_i[20:16]),
    .rdata_o (b_raw)
  );

  // A register never written reads as zero; register zero is never written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
    end else begin
      a_vld_q <= rf_vld_q[instruction_i[25:21]];
      b_vld_q <= rf_vld_q[instruction_i[20:16]];
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
      end
    end
  end

  assign a = a_vld_q ? a_raw : '0;
  assign b = b_vld_q ? b_raw : '0;

  assign opc     = ins_q[31:26];
  assign rt      = ins_q[20:16];
  assign rd      = ins_q[15:11];
  assign sh      = ins_q[10:6];
  assign fn      = ins_q[5:0];
  assign imm     = ins_q[15:0];
  assign simm    = {{16{imm[15]}}, imm};
  assign pc4     = pc_q + 32'd4;
  assign jtarget = {20'd0, text_start_i} + {4'd0, ins_q[25:0], 2'b00};
  assign sum_rr  = {1'b0, a} + {1'b0, b};
  assign sum_ri  = {1'b0, a} + {1'b0, simm};
  assign prod    = a * b;

  // Effective address is taken without wrap, so it is kept as a 34-bit signed value.
  assign idx     = $signed({2'b00, a}) + $signed({{18{imm[15]}}, imm});
  assign idx_end = idx + $signed({31'd0, size});
  assign low     = is_store ? $signed({22'd0, text_start_i}) : '0;
  assign lim     = ({21'd0, memory_limit_i} < MemBytes34) ? $signed({21'd0, memory_limit_i})
                                                          : $signed(MemBytes34);
  assign acc_ok  = !(idx < low) && !(idx_end > lim);
  assign misal   = ((size == 3'd2) && idx[0]) || ((size == 3'd4) && (idx[1:0] != 2'b00));

  always_comb begin
    size     = 3'd1;
    is_load  = 1'b0;
    is_store = 1'b0;
    unique case (opc) inside
      OPC_LB, OPC_LBU: is_load = 1'b1;
      OPC_LH, OPC_LHU: begin
        is_load = 1'b1;
        size    = 3'd2;
      end
      OPC_LW: begin
        is_load = 1'b1;
        size    = 3'd4;
      end
      OPC_SB: is_store = 1'b1;
      OPC_SH: begin
        is_store = 1'b1;
        size     = 3'd2;
      end
      OPC_SW: begin
        is_store = 1'b1;
        size     = 3'd4;
      end
      default: ;
    endcase
  end

  assign is_mem = is_load || is_store;
  assign ba_ext = {9'd0, ba_q};
  assign ba_ok  = {22'd0, ba_q} < MemBytes34;

  // Execute: register write-back, PC, fault and the memory read and write enables.
  always_comb begin
    pc_d    = pc_q;
    fault_d = FAULT_NONE;
    ex_we   = 1'b0;
    ex_wa   = rd;
    ex_wd   = '0;
    ld_ok_d = 1'b0;
    mem_wr  = 1'b0;
    unique case (op_q)
      OP_EXEC: begin
        pc_d = pc4;
        if (opc == OPC_SPECIAL) begin
          unique case (fn) inside
            FN_SLL: begin
              ex_we = 1'b1;
              if ((b & ~(32'hFFFF_FFFF >> sh)) != '0) begin
                fault_d = FAULT_OVF;
              end else begin
                ex_wd = b << sh;
              end
            end
            FN_JR:   pc_d = a;
            FN_MULT: begin
              ex_we = 1'b1;
              ex_wd = prod;
            end
            FN_ADD, FN_ADDU: begin
              ex_we = 1'b1;
              ex_wd = sum_rr[31:0];
              if (sum_rr[32]) begin
                fault_d = FAULT_OVF;
              end
            end
            FN_SUB, FN_SUBU: begin
              ex_we = 1'b1;
              ex_wd = a - b;
            end
            FN_AND: begin
              ex_we = 1'b1;
              ex_wd = a & b;
            end
            FN_OR: begin
              ex_we = 1'b1;
              ex_wd = a | b;
            end
            FN_XOR: begin
              ex_we = 1'b1;
              ex_wd = a ^ b;
            end
            FN_NOR: begin
              ex_we = 1'b1;
              ex_wd = ~(a | b);
            end
            FN_SLT: begin
              ex_we = 1'b1;
              ex_wd = {31'd0, $signed(a) < $signed(b)};
            end
            FN_SLTU: begin
              ex_we = 1'b1;
              ex_wd = {31'd0, a < b};
            end
            default: ;
          endcase
        end else begin
          ex_wa = rt;
          unique case (opc) inside
            OPC_J: pc_d = jtarget;
            OPC_JAL: begin
              pc_d  = jtarget;
              ex_we = 1'b1;
              ex_wa = 5'd31;
              ex_wd = pc4;
            end
            OPC_BEQ: begin
              if (a == b) begin
                pc_d = pc4 + {simm[29:0], 2'b00};
              end
            end
            OPC_BNE: begin
              if (a != b) begin
                pc_d = pc4 + {simm[29:0], 2'b00};
              end
            end
            OPC_ADDI, OPC_ADDIU: begin
              ex_we = 1'b1;
              ex_wd = sum_ri[31:0];
              if (sum_ri[32]) begin
                fault_d = FAULT_OVF;
              end
            end
            OPC_SLTI: begin
              ex_we = 1'b1;
              ex_wd = {31'd0, $signed(a) < $signed(simm)};
            end
            OPC_SLTIU: begin
              ex_we = 1'b1;
              ex_wd = {31'd0, a < simm};
            end
            OPC_ANDI: begin
              ex_we = 1'b1;
              ex_wd = a & {16'd0, imm};
            end
            OPC_ORI: begin
              ex_we = 1'b1;
              ex_wd = a | {16'd0, imm};
            end
            OPC_XORI: begin
              ex_we = 1'b1;
              ex_wd = a ^ {16'd0, imm};
            end
            default: ;
          endcase
          // Out of range is raised after misalignment, so it wins.
          if (is_mem) begin
            if (misal) begin
              fault_d = FAULT_MISAL;
            end
            if (!acc_ok) begin
              fault_d = FAULT_RANGE;
            end else begin
              ld_ok_d = is_load;
              mem_wr  = is_store;
            end
          end
        end
      end
      OP_WRITE, OP_READ: begin
        if (!ba_ok) begin
          fault_d = FAULT_RANGE;
        end else begin
          ld_ok_d = (op_q == OP_READ);
          mem_wr  = (op_q == OP_WRITE);
        end
      end
      default: ;
    endcase
  end

  assign status_o.needs_load = ld_ok_d;

  // Byte lanes: lane k holds the bytes whose address is k modulo four.
  assign off   = (op_q == OP_EXEC) ? idx[1:0] : ba_q[1:0];
  assign wbase = (op_q == OP_EXEC) ? idx[AddrW-1:2] : ba_ext[AddrW-1:2];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [1:0] j;
    assign j = 2'(k) - off;
    assign lane_addr[k] = wbase + ((2'(k) < off) ? WordW'(1) : '0);
    assign lane_wd[k]   = (op_q == OP_EXEC) ? b[8*j +: 8] : bv_q;
    assign lane_we[k]   = cmd_i.exec && mem_wr &&
                          ((op_q == OP_EXEC) ? ({1'b0, j} < size) : (j == 2'd0));

    rieu_ram #(.Width(8), .Depth(Words)) u_lane (
      .clk_i   (clk_i),
      .we_i    (lane_we[k]),
      .waddr_i (lane_addr[k]),
      .wdata_i (lane_wd[k]),
      .raddr_i (lane_addr[k]),
      .rdata_o (lane_rd[k])
    );

    assign ld_word[8*k +: 8] = lane_rd[2'(k) + off_q];
  end

  always_comb begin
    unique case (opc) inside
      OPC_LB:  ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      OPC_LBU: ld_val = {24'd0, ld_word[7:0]};
      OPC_LH:  ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      OPC_LHU: ld_val = {16'd0, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
  end

  // Register file write port: loads write back in the finish step that follows execute; other instructions in execute.
  always_comb begin
    if (cmd_i.finish) begin
      rf_we = ld_ok_q && (op_q == OP_EXEC) && (rt != 5'd0);
      rf_wa = rt;
      rf_wd = ld_val;
    end else begin
      rf_we = cmd_i.exec && ex_we && (ex_wa != 5'd0);
      rf_wa = ex_wa;
      rf_wd = ex_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (cmd_i.exec) begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      fault_q <= fault_d;
      off_q   <= off;
      ld_ok_q <= ld_ok_d;
    end
  end

  assign live_pc    = cmd_i.exec ? pc_d : pc_q;
  assign live_fault = cmd_i.exec ? fault_d : fault_q;
  assign live_rb    = (cmd_i.finish && ld_ok_q && (op_q == OP_READ)) ? lane_rd[ba_q[1:0]]
                                                                     : 8'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      res_pc_q    <= live_pc;
      res_fault_q <= live_fault;
      res_rb_q    <= live_rb;
    end
    if (cmd_i.out_load) begin
      out_pc_q    <= cmd_i.out_sel ? res_pc_q : live_pc;
      out_fault_q <= cmd_i.out_sel ? res_fault_q : live_fault;
      out_rb_q    <= cmd_i.out_sel ? res_rb_q : live_rb;
    end
  end

  assign next_pc_o   = out_pc_q;
  assign fault_o     = out_fault_q;
  assign read_byte_o = out_rb_q;

`ifndef SYNTHESIS
  // Register zero must stay unwritten so that it keeps reading as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rf_wa != 5'd0)
    else $error("write to register zero");

  // Memory is only changed in the execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_we[0] || lane_we[1] || lane_we[2] || lane_we[3]) |-> cmd_i.exec)
    else $error("memory write outside execute");

  // A load completion always follows an accepted in-range read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> ld_ok_q)
    else $error("load completed without a valid access");
`endif

endmodule

/* sv/risc_integer_execute_unit.sv */
// Top level of the integer execute unit: configuration registers and APB decode.
// Instantiates rieu_ctrl and rieu_dp; depends on rieu_pkg.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  operation, instruction, byte_address, byte_value
//   out      output     out_valid_o / out_ready_i  next_pc, fault, read_byte
//   cfg      input      APB psel/penable/pwrite  text_start (0x0), memory_limit (0x4)
//
// An item is accepted in the idle cycle and executes in the next, so the output register is
// loaded from the execute state, or from the load state for loads and memory byte reads,
// because the register file and byte lanes are RAMs with registered reads. The unit takes
// no new item until it is back in the idle state.
// A stalled output holds the finished result in a side register; the next item is taken
// once that result has moved to the output. Reset clears the register file valid bits and
// the PC at once; data memory contents are undefined until written.
module risc_integer_execute_unit #(
  parameter int unsigned MemBytes = rieu_pkg::MEM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] instruction_i,
  input  logic [11:0] byte_address_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_pc_o,
  output logic [1:0]  fault_o,
  output logic [7:0]  read_byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rieu_pkg::*;

  logic [11:0]  text_start_q;
  logic [12:0]  memory_limit_q;
  logic         cfg_wr;
  rieu_cmd_t    cmd;
  rieu_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_start_q   <= '0;
      memory_limit_q <= 13'd4096;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TEXT_START: text_start_q   <= pwdata[11:0];
        REG_MEM_LIMIT:  memory_limit_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_MEM_LIMIT) ? {19'd0, memory_limit_q}
                                              : {20'd0, text_start_q};

  rieu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rieu_dp #(.MemBytes(MemBytes)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .text_start_i   (text_start_q),
    .memory_limit_i (memory_limit_q),
    .operation_i    (operation_i),
    .instruction_i  (instruction_i),
    .byte_address_i (byte_address_i),
    .byte_value_i   (byte_value_i),
    .next_pc_o      (next_pc_o),
    .fault_o        (fault_o),
    .read_byte_o    (read_byte_o)
  );

endmodule
